// File: hw/rtl/ptrw_pkg.sv
// Shared types and constants of the page table run writer.
// No dependencies; imported by ptrw_run_unit, page_table_run_writer and the testbench.
package ptrw_pkg;

    localparam int FIRST_W    = 17;
    localparam int COUNT_W    = 11;
    localparam int PHYS_W     = 40;
    localparam int MEMTYPE_W  = 9;
    localparam int TAG_W      = 15;
    localparam int SHIFT_W    = 5;
    localparam int RUN_LEN_W  = 8;
    localparam int CODE_W     = 3;
    localparam int CODE_MAX   = 7;
    localparam int SHAMT_W    = 6;
    localparam int WORD_W     = 32;
    // Only delta bits up to the top of the tag field ever reach an entry.
    localparam int DELTA_LSB  = 16;
    localparam int DELTA_W    = DELTA_LSB + TAG_W;

    localparam int RUN_LIMIT  = 21;
    localparam int RUN_CNT_W  = 5;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOLEN_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOLEN_BASE   = 2'd1;

    localparam logic [1:0] TARGET_VIDEO  = 2'd0;
    localparam logic [1:0] TARGET_STOLEN = 2'd3;

    typedef struct packed {
        logic [MEMTYPE_W-1:0] memtype;
        logic [TAG_W-1:0]     tag_base;
        logic [SHIFT_W-1:0]   page_shift;
        logic [1:0]           target;
        logic                 sys;
        logic                 wo;
    } t_req_attr;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_BAD  = 3'b100
    } t_state;

endpackage

// File: hw/rtl/page_table_run_writer.sv
// Top level of the page table run writer; built on ptrw_pkg and ptrw_run_unit.
// A request is taken while the sequencer is idle; the run state then loads its runs into the
// output register, one run per cycle while the output is not stalled. The input stays stalled
// until the last run of a request (up to 21 runs) has been loaded.
// Reset is synchronous, active low: it clears the stolen-memory registers,
// returns the sequencer to idle and empties the output register.
module page_table_run_writer
    import ptrw_pkg::*;
#(
    parameter int MAX_COUNT        = 1024,
    parameter int ENTRY_INDEX_BITS = 17,
    parameter int ADDR_BITS        = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [FIRST_W-1:0]          i_first_entry,
    input  logic [COUNT_W-1:0]          i_entry_count,
    input  logic [PHYS_W-1:0]           i_phys_addr,
    input  logic [PHYS_W-1:0]           i_comp_delta,
    input  logic [MEMTYPE_W-1:0]        i_memtype,
    input  logic [TAG_W-1:0]            i_tag_base,
    input  logic [SHIFT_W-1:0]          i_page_shift,
    input  logic                        i_access_sys,
    input  logic                        i_access_wo,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ENTRY_INDEX_BITS-1:0] o_entry_index,
    output logic [RUN_LEN_W-1:0]        o_run_length,
    output logic [WORD_W-1:0]           o_entry_low,
    output logic [WORD_W-1:0]           o_entry_high,
    output logic                        o_last,
    output logic                        o_bad_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [PHYS_W-1:0]           i_cfg_data
);

    t_state                      r_state, n_state;
    logic                        r_stolen_en;
    logic [PHYS_W-1:0]           r_stolen_base;
    t_req_attr                   r_attr;
    logic [ADDR_BITS-1:0]        r_addr;
    logic [DELTA_W-1:0]          r_delta;
    logic [ENTRY_INDEX_BITS-1:0] r_entry;
    logic [COUNT_W-1:0]          r_rem;
    logic [RUN_CNT_W-1:0]        r_nrun;

    logic                        r_out_valid;
    logic [ENTRY_INDEX_BITS-1:0] r_out_entry;
    logic [RUN_LEN_W-1:0]        r_out_len;
    logic [WORD_W-1:0]           r_out_lo;
    logic [WORD_W-1:0]           r_out_hi;
    logic                        r_out_last;
    logic                        r_out_bad;

    logic                        accept;
    logic                        bad;
    logic                        out_load;
    logic                        run_done;
    logic [PHYS_W-1:0]           offset;
    logic [ADDR_BITS-1:0]        addr_sum;
    logic [DELTA_W-1:0]          delta_next;
    logic [ENTRY_INDEX_BITS-1:0] entry_next;
    logic [COUNT_W-1:0]          rem_next;
    logic [RUN_LEN_W-1:0]        len;
    logic [WORD_W-1:0]           lo;
    logic [WORD_W-1:0]           hi;

    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && (r_state == S_IDLE);
    assign bad         = (i_entry_count == '0) || (32'(i_entry_count) > 32'(MAX_COUNT));
    assign out_load    = (r_state != S_IDLE) && (!r_out_valid || !i_stall);
    assign run_done    = (rem_next == '0) || (r_nrun == RUN_CNT_W'(RUN_LIMIT - 1));
    assign offset      = r_stolen_en ? r_stolen_base : '0;
    assign o_cfg_ready = 1'b1;

    ptrw_run_unit #(
        .ADDR_BITS        (ADDR_BITS),
        .ENTRY_INDEX_BITS (ENTRY_INDEX_BITS)
    ) u_run (
        .i_load       (r_state == S_IDLE),
        .i_phys       (i_phys_addr),
        .i_offset     (offset),
        .i_attr       (r_attr),
        .i_addr       (r_addr),
        .i_delta      (r_delta),
        .i_entry      (r_entry),
        .i_rem        (r_rem),
        .o_addr_sum   (addr_sum),
        .o_delta_next (delta_next),
        .o_entry_next (entry_next),
        .o_rem_next   (rem_next),
        .o_len        (len),
        .o_lo         (lo),
        .o_hi         (hi)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = bad ? S_BAD : S_RUN;
                end
            end
            S_RUN: begin
                if (out_load && run_done) begin
                    n_state = S_IDLE;
                end
            end
            S_BAD: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_stolen_en   <= 1'b0;
            r_stolen_base <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STOLEN_ENABLE: r_stolen_en   <= i_cfg_data[0];
                    CFG_STOLEN_BASE:   r_stolen_base <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Walk state; loaded from the request, then advanced once per emitted run.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= addr_sum;
            r_delta <= i_comp_delta[DELTA_W-1:0];
            r_entry <= ENTRY_INDEX_BITS'(i_first_entry);
            r_rem   <= i_entry_count;
            r_nrun  <= '0;
            r_attr  <= '{memtype:    i_memtype,
                         tag_base:   i_tag_base,
                         page_shift: i_page_shift,
                         target:     r_stolen_en ? TARGET_STOLEN : TARGET_VIDEO,
                         sys:        i_access_sys,
                         wo:         i_access_wo};
        end else if (r_state == S_RUN && out_load) begin
            r_addr  <= addr_sum;
            r_delta <= delta_next;
            r_entry <= entry_next;
            r_rem   <= rem_next;
            r_nrun  <= r_nrun + RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == S_BAD) begin
                r_out_entry <= '0;
                r_out_len   <= '0;
                r_out_lo    <= '0;
                r_out_hi    <= '0;
                r_out_last  <= 1'b1;
                r_out_bad   <= 1'b1;
            end else begin
                r_out_entry <= r_entry;
                r_out_len   <= len;
                r_out_lo    <= lo;
                r_out_hi    <= hi;
                r_out_last  <= (rem_next == '0);
                r_out_bad   <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_entry_index = r_out_entry;
    assign o_run_length  = r_out_len;
    assign o_entry_low   = r_out_lo;
    assign o_entry_high  = r_out_hi;
    assign o_last        = r_out_last;
    assign o_bad_count   = r_out_bad;

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_count |-> o_last && o_run_length == '0)
        else $error("bad-count result carries a run");

    a_len_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_count |-> $onehot(o_run_length))
        else $error("run length is not a power of two");

    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_rem != '0)
        else $error("walking with no entries left");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN && out_load && rem_next == '0 |=> r_state == S_IDLE)
        else $error("sequencer kept running after the final run");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_nrun < RUN_CNT_W'(RUN_LIMIT))
        else $error("run count exceeded its limit");

endmodule

// File: hw/rtl/ptrw_run_unit.sv
// Run unit: picks the run size, builds both entry words and advances the walk.
// The address adder is shared between the stolen-base add and the per-run step.
// Depends on ptrw_pkg.
module ptrw_run_unit
    import ptrw_pkg::*;
#(
    parameter int ADDR_BITS        = 40,
    parameter int ENTRY_INDEX_BITS = 17
) (
    input  logic                        i_load,
    input  logic [PHYS_W-1:0]           i_phys,
    input  logic [PHYS_W-1:0]           i_offset,
    input  t_req_attr                   i_attr,
    input  logic [ADDR_BITS-1:0]        i_addr,
    input  logic [DELTA_W-1:0]          i_delta,
    input  logic [ENTRY_INDEX_BITS-1:0] i_entry,
    input  logic [COUNT_W-1:0]          i_rem,
    output logic [ADDR_BITS-1:0]        o_addr_sum,
    output logic [DELTA_W-1:0]          o_delta_next,
    output logic [ENTRY_INDEX_BITS-1:0] o_entry_next,
    output logic [COUNT_W-1:0]          o_rem_next,
    output logic [RUN_LEN_W-1:0]        o_len,
    output logic [WORD_W-1:0]           o_lo,
    output logic [WORD_W-1:0]           o_hi
);

    logic [CODE_W-1:0]   code;
    logic [SHAMT_W-1:0]  shamt;
    logic [PHYS_W-1:0]   step;
    logic [PHYS_W-1:0]   add_a;
    logic [PHYS_W-1:0]   add_b;
    logic [PHYS_W-1:0]   sum;
    logic [PHYS_W-1:0]   addr_ext;
    logic [1:0]          comp;
    logic [TAG_W+1:0]    tag_prod;
    logic [TAG_W-1:0]    tag;

    // Both conditions only weaken as the size shrinks, so the largest size
    // that passes is the run size; a single entry always passes.
    always_comb begin
        code = '0;
        for (int c = 1; c <= CODE_MAX; c++) begin
            if ((i_rem >> c) != '0 &&
                (i_entry & ENTRY_INDEX_BITS'((1 << c) - 1)) == '0) begin
                code = CODE_W'(c);
            end
        end
    end

    assign o_len = RUN_LEN_W'(1) << code;
    assign shamt = SHAMT_W'(code) + SHAMT_W'(i_attr.page_shift);
    assign step  = PHYS_W'(1) << shamt;

    assign add_a      = i_load ? i_phys   : PHYS_W'(i_addr);
    assign add_b      = i_load ? i_offset : step;
    assign sum        = add_a + add_b;
    assign o_addr_sum = ADDR_BITS'(sum);

    assign o_delta_next = i_delta + step[DELTA_W-1:0];
    assign o_entry_next = i_entry + ENTRY_INDEX_BITS'(o_len);
    assign o_rem_next   = i_rem - COUNT_W'(o_len);

    assign addr_ext = PHYS_W'(i_addr);
    assign comp     = i_attr.memtype[MEMTYPE_W-1:MEMTYPE_W-2];
    assign tag_prod = (TAG_W+2)'(i_delta[DELTA_W-1:DELTA_LSB]) * (TAG_W+2)'(comp);
    assign tag      = i_attr.tag_base + tag_prod[TAG_W-1:0];

    assign o_lo = addr_ext[WORD_W-1:0] |
                  {22'd0, code, i_attr.sys, i_attr.target, ~i_attr.wo, 2'b00, 1'b1};
    assign o_hi = {(comp != 2'd0) ? tag : '0, i_attr.memtype, addr_ext[PHYS_W-1:WORD_W]};

endmodule

// File: bench/tb_page_table_run_writer.sv
`timescale 1ns / 100ps
// Testbench for page_table_run_writer: sends mapping requests and compares every emitted
// run against the run given in a directed row, else a predictor that tracks the stolen-memory registers.
// Depends on ptrw_pkg and the page_table_run_writer RTL.
module tb_page_table_run_writer
    import ptrw_pkg::*;
();

    localparam int IDX_W           = 17;
    localparam int MAX_REQ_COUNT   = 1024;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 58;

    typedef struct packed {
        logic [FIRST_W-1:0]   first_entry;
        logic [COUNT_W-1:0]   entry_count;
        logic [PHYS_W-1:0]    phys_addr;
        logic [PHYS_W-1:0]    comp_delta;
        logic [MEMTYPE_W-1:0] memtype;
        logic [TAG_W-1:0]     tag_base;
        logic [SHIFT_W-1:0]   page_shift;
        logic                 access_sys;
        logic                 access_wo;
    } t_map_req;

    typedef struct packed {
        logic [IDX_W-1:0]     entry_index;
        logic [RUN_LEN_W-1:0] run_length;
        logic [WORD_W-1:0]    entry_low;
        logic [WORD_W-1:0]    entry_high;
        logic                 last;
        logic                 bad_count;
    } t_pte_run;

    typedef struct packed {
        t_map_req rq;
        logic     typed;
        t_pte_run want;
    } t_dir_row;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    localparam t_pte_run NO_RUN  = '0;
    localparam t_pte_run BAD_RUN = {17'd0, 8'd0, 32'd0, 32'd0, 1'b1, 1'b1};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [FIRST_W-1:0]   i_first_entry;
    logic [COUNT_W-1:0]   i_entry_count;
    logic [PHYS_W-1:0]    i_phys_addr;
    logic [PHYS_W-1:0]    i_comp_delta;
    logic [MEMTYPE_W-1:0] i_memtype;
    logic [TAG_W-1:0]     i_tag_base;
    logic [SHIFT_W-1:0]   i_page_shift;
    logic                 i_access_sys;
    logic                 i_access_wo;
    logic                 o_valid;
    logic                 i_stall;
    logic [IDX_W-1:0]     o_entry_index;
    logic [RUN_LEN_W-1:0] o_run_length;
    logic [WORD_W-1:0]    o_entry_low;
    logic [WORD_W-1:0]    o_entry_high;
    logic                 o_last;
    logic                 o_bad_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [PHYS_W-1:0]    i_cfg_data;

    // Predictor copy of the configuration registers.
    logic                 stolen_on;
    logic [PHYS_W-1:0]    stolen_offset;

    t_pte_run expected_runs[$];
    t_dir_row dir_table[$];
    int       error_count;
    int       req_total;
    int       bad_total;
    int       run_total;
    int       burst_left;
    bit       long_hold_req;

    page_table_run_writer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_first_entry (i_first_entry),
        .i_entry_count (i_entry_count),
        .i_phys_addr   (i_phys_addr),
        .i_comp_delta  (i_comp_delta),
        .i_memtype     (i_memtype),
        .i_tag_base    (i_tag_base),
        .i_page_shift  (i_page_shift),
        .i_access_sys  (i_access_sys),
        .i_access_wo   (i_access_wo),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_entry_index (o_entry_index),
        .o_run_length  (o_run_length),
        .o_entry_low   (o_entry_low),
        .o_entry_high  (o_entry_high),
        .o_last        (o_last),
        .o_bad_count   (o_bad_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 30) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    // Splits one mapping request into its runs of identical entries; an out-of-range count gives the bad-count result.
    function automatic void predict_runs(input t_map_req rq);
        t_pte_run          rn;
        logic [PHYS_W-1:0] addr;
        logic [PHYS_W:0]   delta;
        logic [IDX_W-1:0]  entry;
        logic [COUNT_W-1:0] left;
        logic [1:0]        comp;
        logic [1:0]        tgt;
        logic [RUN_LEN_W-1:0] len;
        logic [PHYS_W-1:0] adv;
        logic [63:0]       tag;
        logic [WORD_W-1:0] flags;
        int                c;
        int                nruns;
        if (rq.entry_count == 0 || int'(rq.entry_count) > MAX_REQ_COUNT) begin
            expected_runs.push_back(BAD_RUN);
            return;
        end
        comp  = rq.memtype[8:7];
        tgt   = stolen_on ? TARGET_STOLEN : TARGET_VIDEO;
        addr  = rq.phys_addr + (stolen_on ? stolen_offset : PHYS_W'(0));
        delta = {1'b0, rq.comp_delta};
        entry = rq.first_entry;
        left  = rq.entry_count;
        flags = {25'd0, rq.access_sys, tgt, ~rq.access_wo, 3'b001};
        nruns = 0;
        while (left != 0 && nruns < RUN_LIMIT) begin
            // Largest power of two that fits the remaining count and the entry alignment.
            c = CODE_MAX;
            while (c > 0 && !(int'(left) >= (1 << c) && (int'(entry) & ((1 << c) - 1)) == 0))
                c--;
            len = RUN_LEN_W'(1 << c);
            adv = PHYS_W'(64'(len) << rq.page_shift);
            rn.entry_index = entry;
            rn.run_length  = len;
            rn.entry_low   = addr[31:0] | flags | (WORD_W'(c) << 7);
            rn.entry_high  = {15'd0, rq.memtype, addr[39:32]};
            if (comp != 0) begin
                tag = 64'(rq.tag_base) + 64'(delta >> DELTA_LSB) * 64'(comp);
                rn.entry_high[31:17] = tag[14:0];
            end
            left = left - COUNT_W'(len);
            rn.last      = (left == 0);
            rn.bad_count = 1'b0;
            expected_runs.push_back(rn);
            addr = addr + adv;
            if (comp != 0) begin
                delta = delta + {1'b0, adv};
            end
            entry = entry + IDX_W'(len);
            nruns++;
        end
    endfunction

    function automatic t_map_req random_request();
        t_map_req    rq;
        logic [63:0] w;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            rq.entry_count = (pick < 3) ? COUNT_W'(0)
                                        : COUNT_W'($urandom_range(MAX_REQ_COUNT + 1, 2047));
        else if (pick < 70)
            rq.entry_count = COUNT_W'($urandom_range(1, 64));
        else if (pick < 94)
            rq.entry_count = COUNT_W'($urandom_range(65, MAX_REQ_COUNT - 1));
        else
            rq.entry_count = COUNT_W'(MAX_REQ_COUNT);
        w = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 40)
            rq.first_entry = w[16:0];
        else if (pick < 80)
            rq.first_entry = {w[16:7], 7'd0};
        else
            rq.first_entry = 17'h1FFFF - FIRST_W'(w[8:0]);
        w = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 50)
            rq.phys_addr = {w[39:12], 12'd0};
        else if (pick < 65)
            rq.phys_addr = {24'hFF_FFFF, w[15:0]};
        else
            rq.phys_addr = w[39:0];
        w = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 15)
            rq.comp_delta = {24'hFF_FFFF, w[15:0]};
        else if (pick < 25)
            rq.comp_delta = '0;
        else
            rq.comp_delta = w[39:0];
        rq.memtype  = MEMTYPE_W'($urandom);
        rq.tag_base = TAG_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            rq.page_shift = SHIFT_W'(12);
        else if (pick < 80)
            rq.page_shift = SHIFT_W'(16);
        else if (pick < 90)
            rq.page_shift = SHIFT_W'($urandom_range(13, 15));
        else
            rq.page_shift = SHIFT_W'($urandom_range(0, 31));
        rq.access_sys = 1'($urandom);
        rq.access_wo  = 1'($urandom);
        return rq;
    endfunction

    // Offers one request, with a random gap at the start of each burst.
    task automatic send_request(input t_map_req rq, input logic typed, input t_pte_run want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 5));
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_first_entry <= rq.first_entry;
        i_entry_count <= rq.entry_count;
        i_phys_addr   <= rq.phys_addr;
        i_comp_delta  <= rq.comp_delta;
        i_memtype     <= rq.memtype;
        i_tag_base    <= rq.tag_base;
        i_page_shift  <= rq.page_shift;
        i_access_sys  <= rq.access_sys;
        i_access_wo   <= rq.access_wo;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (typed)
            expected_runs.push_back(want);
        else
            predict_runs(rq);
        req_total++;
        if (rq.entry_count == 0 || int'(rq.entry_count) > MAX_REQ_COUNT)
            bad_total++;
    endtask

    task automatic write_settings(input logic en, input logic [PHYS_W-1:0] base);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_STOLEN_ENABLE;
        i_cfg_data  <= {{(PHYS_W - 1){1'b0}}, en};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        stolen_on = en;
        i_cfg_index <= CFG_STOLEN_BASE;
        i_cfg_data  <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        stolen_offset = base;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_run();
        t_pte_run want;
        if (expected_runs.size() == 0) begin
            flag_error($sformatf("run at entry %0h with no request pending", o_entry_index));
            return;
        end
        want = expected_runs.pop_front();
        run_total++;
        compare_field("entry_index", 64'(o_entry_index), 64'(want.entry_index));
        compare_field("run_length", 64'(o_run_length), 64'(want.run_length));
        compare_field("entry_low", 64'(o_entry_low), 64'(want.entry_low));
        compare_field("entry_high", 64'(o_entry_high), 64'(want.entry_high));
        compare_field("last", 64'(o_last), 64'(want.last));
        compare_field("bad_count", 64'(o_bad_count), 64'(want.bad_count));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0 && !i_stall) begin
            check_run();
        end
    end

    // Output backpressure: random modes, plus an occasional long hold so the block fills.
    initial begin : receiver
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        i_stall <= 1'b0;
        mode = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = 160;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                tick++;
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
                    default:     i_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [63:0]       w;
        logic              en;
        logic [PHYS_W-1:0] base;
        int                ph;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_first_entry <= '0;
        i_entry_count <= '0;
        i_phys_addr   <= '0;
        i_comp_delta  <= '0;
        i_memtype     <= '0;
        i_tag_base    <= '0;
        i_page_shift  <= '0;
        i_access_sys  <= 1'b0;
        i_access_wo   <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_STOLEN_ENABLE;
        i_cfg_data    <= '0;
        stolen_on     = 1'b0;
        stolen_offset = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Each row: first, count, phys, delta, memtype, tag, shift, sys, wo;
        // then whether the run is given here, and that run.
        dir_table.push_back({17'd0, 11'd1, 40'h0, 40'h0, 9'h000, 15'h0000, 5'd12, 1'b0, 1'b0,
                             1'b1, 17'd0, 8'd1, 32'h0000_0009, 32'h0, 1'b1, 1'b0});
        dir_table.push_back({17'd5, 11'd0, 40'h12_3456_7000, 40'h1_0000, 9'h180, 15'h1234,
                             5'd12, 1'b1, 1'b0, 1'b1, BAD_RUN});
        dir_table.push_back({17'd0, 11'd1025, 40'h0, 40'h0, 9'h080, 15'h0001, 5'd12, 1'b0, 1'b0,
                             1'b1, BAD_RUN});
        dir_table.push_back({17'h1FFFF, 11'd2047, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 9'h1FF,
                             15'h7FFF, 5'd31, 1'b1, 1'b1, 1'b1, BAD_RUN});
        dir_table.push_back({17'h1FFFF, 11'd1, 40'hFF_FFFF_FFFF, 40'h0, 9'h07F, 15'h7FFF, 5'd16,
                             1'b1, 1'b1,
                             1'b1, 17'h1FFFF, 8'd1, 32'hFFFF_FFFF, 32'h0000_7FFF, 1'b1, 1'b0});
        dir_table.push_back({17'd0, 11'd128, 40'h0, 40'h0, 9'h000, 15'h0000, 5'd12, 1'b0, 1'b1,
                             1'b1, 17'd0, 8'd128, 32'h0000_0381, 32'h0, 1'b1, 1'b0});
        dir_table.push_back({17'd0, 11'd1024, 40'h01_0000_0000, 40'h0, 9'h000, 15'h0, 5'd12,
                             1'b0, 1'b0, 1'b0, NO_RUN});
        dir_table.push_back({17'd1, 11'd1024, 40'h00_8000_0000, 40'h0, 9'h080, 15'h0010, 5'd12,
                             1'b1, 1'b0, 1'b0, NO_RUN});
        // Entry index wraps past the top of the table.
        dir_table.push_back({17'h1FFFF, 11'd1024, 40'h0, 40'h0, 9'h100, 15'h0100, 5'd16,
                             1'b0, 1'b0, 1'b0, NO_RUN});
        // Tag overflows its 15-bit field.
        dir_table.push_back({17'd64, 11'd200, 40'h00_4000_0000, 40'h00_0123_0000, 9'h1FF,
                             15'h7FFF, 5'd16, 1'b0, 1'b1, 1'b0, NO_RUN});
        // Address carries out of the top bit.
        dir_table.push_back({17'd0, 11'd32, 40'hFF_FFFF_8000, 40'h0, 9'h000, 15'h0, 5'd12,
                             1'b0, 1'b0, 1'b0, NO_RUN});
        dir_table.push_back({17'd3, 11'd1024, 40'h0, 40'hFF_FFFF_FFFF, 9'h180, 15'h7FFF, 5'd16,
                             1'b1, 1'b1, 1'b0, NO_RUN});
        dir_table.push_back({17'd8, 11'd100, 40'h00_0000_1000, 40'h0, 9'h080, 15'h0001, 5'd0,
                             1'b0, 1'b0, 1'b0, NO_RUN});
        dir_table.push_back({17'd0, 11'd300, 40'h0, 40'h00_0001_0000, 9'h180, 15'h0002, 5'd31,
                             1'b0, 1'b0, 1'b0, NO_RUN});
        dir_table.push_back({17'd16, 11'd77, 40'h00_2000_0000, 40'h0, 9'h100, 15'h0005, 5'd13,
                             1'b1, 1'b0, 1'b0, NO_RUN});
        // Low address bits land on top of the flag bits.
        dir_table.push_back({17'd2, 11'd5, 40'h12_3456_7FFF, 40'h0, 9'h0AA, 15'h0, 5'd12,
                             1'b0, 1'b0, 1'b0, NO_RUN});
        dir_table.push_back({17'd127, 11'd129, 40'h00_1000_0000, 40'h00_0ABC_DEF0, 9'h155,
                             15'h2AAA, 5'd14, 1'b1, 1'b1, 1'b0, NO_RUN});
        dir_table.push_back({17'h15555, 11'd1023, 40'hAA_AAAA_A000, 40'h55_5555_5000, 9'h0C0,
                             15'h5555, 5'd15, 1'b0, 1'b1, 1'b0, NO_RUN});
        dir_table.push_back({17'h0AAAA, 11'd3, 40'h55_5555_5000, 40'hAA_AAAA_A000, 9'h140,
                             15'h2AAA, 5'd12, 1'b1, 1'b1, 1'b0, NO_RUN});
        // Odd start and count give twenty runs, close to the most one request can take.
        dir_table.push_back({17'd1, 11'd1022, 40'h0, 40'h0, 9'h000, 15'h0, 5'd12, 1'b0, 1'b0,
                             1'b0, NO_RUN});
        foreach (dir_table[i]) begin
            send_request(dir_table[i].rq, dir_table[i].typed, dir_table[i].want);
        end
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            w = {$urandom, $urandom};
            case (ph)
                0:       begin en = 1'b1; base = '1;      end
                1:       begin en = 1'b1; base = '0;      end
                2:       begin en = 1'b0; base = w[39:0]; end
                5:       begin en = 1'b0; base = '0;      end
                default: begin en = 1'b1; base = w[39:0]; end
            endcase
            write_settings(en, base);
            if (ph == 1 || ph == 4) begin
                long_hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, NO_RUN);
            drain();
        end

        // Window for any stray run after the last expected one.
        repeat (25) @(posedge i_clk);
        $display("Covered %0d mapping requests (%0d with an out-of-range count), %0d runs.",
                 req_total, bad_total, run_total);
        $display("Stolen memory was off, at base zero, at the top base and at random bases.");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
